// ===== design/scma_pkg.sv =====
// ----------------------------------------------------------------------------
// scma_pkg
// Shared types and constants of the sparse coordinate-form merge-add unit:
// store sizing, request and status codes, the stored element layout and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package scma_pkg;

    // Store sizing.
    localparam int STORE_DEPTH = 32;
    localparam int INDEX_BITS  = 16;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // Field widths.
    localparam int IDX_W  = 16;
    localparam int VAL_W  = 32;
    localparam int DATA_W = 2 * IDX_W + VAL_W;

    // Only the low INDEX_BITS bits of an index take effect.
    localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'((33'd1 << INDEX_BITS) - 33'd1);

    // Request codes carried on the input tuser.
    localparam logic [1:0] REQ_LOAD_A = 2'd0;
    localparam logic [1:0] REQ_LOAD_B = 2'd1;
    localparam logic [1:0] REQ_MERGE  = 2'd2;

    // Status codes carried on the output tuser.
    localparam logic [1:0] STAT_ELEMENT = 2'd0;
    localparam logic [1:0] STAT_EMPTY   = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;
    localparam logic [1:0] STAT_ORDER   = 2'd3;

    // One stored element; the packing matches the output tdata layout.
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        col;
        logic [IDX_W-1:0]        row;
    } entry_t;

    // Controller states.
    typedef enum logic {
        CTRL_IDLE,
        CTRL_MERGE
    } ctrl_state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic accept_load;  // a load beat is taken this cycle
        logic clear_idx;    // hold the merge read pointers at zero
        logic step;         // emit one merge result
    } cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic load_err;     // the presented load would be refused
        logic step_last;    // the current merge result is the final one
        logic out_free;     // the output register can take a result
    } sts_t;

endpackage

// ===== design/scma_ctrl.sv =====
// ----------------------------------------------------------------------------
// scma_ctrl
// Controller of the merge-add unit. Takes input beats while idle and steps
// the datapath through a merge, one result per cycle the output allows.
// ----------------------------------------------------------------------------
module scma_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    input  logic [1:0]     req_type,
    output logic           s_tready,
    input  scma_pkg::sts_t sts,
    output scma_pkg::cmd_t cmd
);
    import scma_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        is_load;
    logic        accept;

    assign is_load = (req_type == REQ_LOAD_A) || (req_type == REQ_LOAD_B);

    // A refused load needs the output register; everything else does not.
    assign s_tready = (state_reg == CTRL_IDLE) && (sts.out_free || !(is_load && sts.load_err));
    assign accept   = s_tvalid && s_tready;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CTRL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CTRL_IDLE: begin
                if (accept && (req_type == REQ_MERGE)) begin
                    state_next = CTRL_MERGE;
                end
            end
            CTRL_MERGE: begin
                if (sts.out_free && sts.step_last) begin
                    state_next = CTRL_IDLE;
                end
            end
            default: state_next = CTRL_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        cmd = '0;
        unique case (state_reg)
            CTRL_IDLE: begin
                cmd.clear_idx   = 1'b1;
                cmd.accept_load = accept && is_load;
            end
            CTRL_MERGE: begin
                cmd.step = sts.out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule

// ===== design/scma_dpath.sv =====
// ----------------------------------------------------------------------------
// scma_dpath
// Datapath of the merge-add unit: the two element stores, their counts and
// last positions, the merge pointers and comparator, the saturating adder
// and the output register.
// ----------------------------------------------------------------------------
module scma_dpath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [1:0]                     req_type,
    input  logic [scma_pkg::IDX_W-1:0]     in_row,
    input  logic [scma_pkg::IDX_W-1:0]     in_col,
    input  logic signed [scma_pkg::VAL_W-1:0] in_value,
    input  scma_pkg::cmd_t                 cmd,
    output scma_pkg::sts_t                 sts,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [scma_pkg::DATA_W-1:0]    m_tdata,
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast
);
    import scma_pkg::*;

    // Element stores.
    entry_t mem_a [STORE_DEPTH];
    entry_t mem_b [STORE_DEPTH];
    entry_t rd_a_reg;
    entry_t rd_b_reg;

    // Fill state of each store.
    logic [CNT_W-1:0] a_cnt_reg, a_cnt_next;
    logic [CNT_W-1:0] b_cnt_reg, b_cnt_next;
    logic [IDX_W-1:0] a_lrow_reg, a_lrow_next, a_lcol_reg, a_lcol_next;
    logic [IDX_W-1:0] b_lrow_reg, b_lrow_next, b_lcol_reg, b_lcol_next;

    // Merge read pointers.
    logic [CNT_W-1:0] ka_reg, ka_next, ka_adv;
    logic [CNT_W-1:0] kb_reg, kb_next, kb_adv;

    // Output register.
    logic         out_valid_reg, out_valid_next;
    entry_t       out_data_reg, out_data_next;
    logic [1:0]   out_stat_reg, out_stat_next;
    logic         out_last_reg, out_last_next;

    // Load checks.
    logic             sel_b;
    logic [IDX_W-1:0] ld_row, ld_col;
    logic [CNT_W-1:0] sel_cnt;
    logic [IDX_W-1:0] sel_lrow, sel_lcol;
    logic             full, order_ok;
    entry_t           ld_entry;
    logic             wr_a, wr_b;

    // Merge compare.
    logic                    va, vb, a_first, same, take_a, take_b;
    logic signed [VAL_W:0]   sum;
    logic signed [VAL_W-1:0] sat_sum;
    entry_t                  mg_entry;
    logic                    mg_empty;

    // Load checks against the selected store.
    assign sel_b    = (req_type == REQ_LOAD_B);
    assign ld_row   = in_row & IDX_MASK;
    assign ld_col   = in_col & IDX_MASK;
    assign sel_cnt  = sel_b ? b_cnt_reg : a_cnt_reg;
    assign sel_lrow = sel_b ? b_lrow_reg : a_lrow_reg;
    assign sel_lcol = sel_b ? b_lcol_reg : a_lcol_reg;
    assign full     = (sel_cnt >= CNT_W'(STORE_DEPTH));
    assign order_ok = (sel_cnt == '0) || (ld_row > sel_lrow) ||
                      ((ld_row == sel_lrow) && (ld_col > sel_lcol));
    assign ld_entry = '{value: in_value, col: ld_col, row: ld_row};
    assign wr_a     = cmd.accept_load && !sts.load_err && !sel_b;
    assign wr_b     = cmd.accept_load && !sts.load_err && sel_b;

    // Merge comparison of the two head elements.
    assign va      = (ka_reg < a_cnt_reg);
    assign vb      = (kb_reg < b_cnt_reg);
    assign a_first = (rd_a_reg.row < rd_b_reg.row) ||
                     ((rd_a_reg.row == rd_b_reg.row) && (rd_a_reg.col < rd_b_reg.col));
    assign same    = (rd_a_reg.row == rd_b_reg.row) && (rd_a_reg.col == rd_b_reg.col);
    always_comb begin
        if (va && vb) begin
            take_a = a_first || same;
            take_b = !a_first;
        end else begin
            take_a = va;
            take_b = !va;
        end
    end
    assign mg_empty = !va && !vb;
    assign ka_adv   = ka_reg + CNT_W'(take_a && va);
    assign kb_adv   = kb_reg + CNT_W'(take_b && vb);

    // Saturating sum of coinciding values.
    assign sum = {rd_a_reg.value[VAL_W-1], rd_a_reg.value} +
                 {rd_b_reg.value[VAL_W-1], rd_b_reg.value};
    always_comb begin
        if (sum[VAL_W] != sum[VAL_W-1]) begin
            sat_sum = sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
            sat_sum = sum[VAL_W-1:0];
        end
    end

    // Element chosen for this merge step.
    always_comb begin
        if (mg_empty) begin
            mg_entry = '0;
        end else if (take_a && take_b) begin
            mg_entry = '{value: sat_sum, col: rd_a_reg.col, row: rd_a_reg.row};
        end else if (take_a) begin
            mg_entry = rd_a_reg;
        end else begin
            mg_entry = rd_b_reg;
        end
    end

    // Status to the controller.
    assign sts.load_err  = full || !order_ok;
    assign sts.step_last = mg_empty || ((ka_adv >= a_cnt_reg) && (kb_adv >= b_cnt_reg));
    assign sts.out_free  = !out_valid_reg || m_tready;

    // Pointer update; the stores are read at the next pointer values.
    always_comb begin
        if (cmd.clear_idx) begin
            ka_next = '0;
            kb_next = '0;
        end else if (cmd.step) begin
            ka_next = ka_adv;
            kb_next = kb_adv;
        end else begin
            ka_next = ka_reg;
            kb_next = kb_reg;
        end
    end

    // Counts and last positions.
    always_comb begin
        a_cnt_next  = a_cnt_reg;
        b_cnt_next  = b_cnt_reg;
        a_lrow_next = a_lrow_reg;
        a_lcol_next = a_lcol_reg;
        b_lrow_next = b_lrow_reg;
        b_lcol_next = b_lcol_reg;
        if (cmd.step && sts.step_last) begin
            a_cnt_next  = '0;
            b_cnt_next  = '0;
            a_lrow_next = '0;
            a_lcol_next = '0;
            b_lrow_next = '0;
            b_lcol_next = '0;
        end else if (wr_a) begin
            a_cnt_next  = a_cnt_reg + CNT_W'(1);
            a_lrow_next = ld_row;
            a_lcol_next = ld_col;
        end else if (wr_b) begin
            b_cnt_next  = b_cnt_reg + CNT_W'(1);
            b_lrow_next = ld_row;
            b_lcol_next = ld_col;
        end
    end

    // Output register contents.
    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_stat_next  = out_stat_reg;
        out_last_next  = out_last_reg;
        if (cmd.accept_load && sts.load_err) begin
            out_valid_next = 1'b1;
            out_data_next  = '{value: '0, col: ld_col, row: ld_row};
            out_stat_next  = full ? STAT_FULL : STAT_ORDER;
            out_last_next  = 1'b1;
        end else if (cmd.step) begin
            out_valid_next = 1'b1;
            out_data_next  = mg_entry;
            out_stat_next  = mg_empty ? STAT_EMPTY : STAT_ELEMENT;
            out_last_next  = sts.step_last;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_cnt_reg     <= '0;
            b_cnt_reg     <= '0;
            a_lrow_reg    <= '0;
            a_lcol_reg    <= '0;
            b_lrow_reg    <= '0;
            b_lcol_reg    <= '0;
            ka_reg        <= '0;
            kb_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            a_cnt_reg     <= a_cnt_next;
            b_cnt_reg     <= b_cnt_next;
            a_lrow_reg    <= a_lrow_next;
            a_lcol_reg    <= a_lcol_next;
            b_lrow_reg    <= b_lrow_next;
            b_lcol_reg    <= b_lcol_next;
            ka_reg        <= ka_next;
            kb_reg        <= kb_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_stat_reg <= out_stat_next;
        out_last_reg <= out_last_next;
    end

    // Store A: one write port at the fill count, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_a) begin
            mem_a[a_cnt_reg[ADDR_W-1:0]] <= ld_entry;
        end
        rd_a_reg <= mem_a[ka_next[ADDR_W-1:0]];
    end

    // Store B: one write port at the fill count, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_b) begin
            mem_b[b_cnt_reg[ADDR_W-1:0]] <= ld_entry;
        end
        rd_b_reg <= mem_b[kb_next[ADDR_W-1:0]];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_stat_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== design/sparse_coo_merge_add_unit.sv =====
// ----------------------------------------------------------------------------
// sparse_coo_merge_add_unit
// Loads two sparse matrices in row-major coordinate form and emits their
// saturated element-wise sum as a merged row-major stream.
// A refused load shows its error beat in the cycle after acceptance; an
// accepted load gives no beat. A merge's first beat passes the controller
// state register and then the output register, then one beat per cycle as
// the output allows; the merge loop advances one result per cycle over the
// store read ports while the output allows.
// Reset (aresetn low, synchronous) empties both stores and the output.
// ----------------------------------------------------------------------------
module sparse_coo_merge_add_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Input channel.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [scma_pkg::DATA_W-1:0] s_tdata,  // in_row, in_col, in_value
    input  logic [1:0]                  s_tuser,  // req_type
    // Result channel.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [scma_pkg::DATA_W-1:0] m_tdata,  // out_row, out_col, out_value
    output logic [1:0]                  m_tuser,  // out_status
    output logic                        m_tlast
);
    import scma_pkg::*;

    cmd_t   cmd;
    sts_t   sts;
    entry_t s_entry;

    assign s_entry = s_tdata;

    // Request sequencing.
    scma_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .req_type (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Stores, merge and output register.
    scma_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req_type (s_tuser),
        .in_row   (s_entry.row),
        .in_col   (s_entry.col),
        .in_value (s_entry.value),
        .cmd      (cmd),
        .sts      (sts),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
